/* rtl/core/ofbp_pkg.sv */
// Shared types, codes and constants of the object frame byte parser.
package ofbp_pkg;

    // Default cap on the object count, whatever the limit register holds.
    localparam int unsigned COUNT_LIMIT_MAX_DEF = 100000;

    // Limit register after reset; 10000 suits 2D frames, 100000 suits 3D frames.
    localparam logic [16:0] MAX_OBJECTS_RESET = 17'd10000;
    localparam logic [16:0] MAX_OBJECTS_3D    = 17'd100000;

    // Frame number, timestamp, marker and count together.
    localparam int unsigned HEADER_BYTES = 17;

    // Depth of the record queue in front of the output.
    localparam int unsigned OUT_DEPTH = 4;

    localparam logic [7:0] CH_MARKER = 8'h5E;  // '^'
    localparam logic [7:0] CH_DELIM  = 8'h7C;  // '|'

    // Record kinds.
    localparam logic [1:0] REC_HEADER = 2'd0;
    localparam logic [1:0] REC_OBJECT = 2'd1;
    localparam logic [1:0] REC_DONE   = 2'd2;

    // Frame status codes; the error codes double as the stored first error.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_TRUNCATED  = 3'd2;
    localparam logic [2:0] ST_NO_MARKER  = 3'd3;
    localparam logic [2:0] ST_NEG_COUNT  = 3'd4;
    localparam logic [2:0] ST_OVER_LIMIT = 3'd5;
    localparam logic [2:0] ST_NO_DELIM   = 3'd6;
    localparam logic [2:0] ST_TRAILING   = 3'd7;

    typedef enum logic [3:0] {
        PH_FRAME_NO  = 4'd0,
        PH_TIMESTAMP = 4'd1,
        PH_MARKER    = 4'd2,
        PH_COUNT     = 4'd3,
        PH_DELIM     = 4'd4,
        PH_IDENT     = 4'd5,
        PH_CLASS     = 4'd6,
        PH_COORD_A   = 4'd7,
        PH_COORD_B   = 4'd8,
        PH_COORD_C   = 4'd9,
        PH_TAIL      = 4'd10,
        PH_END       = 4'd11
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [1:0]         record_kind;
        logic signed [31:0] frame_num;
        logic [63:0]        timestamp_bits;
        logic [16:0]        object_count;
        logic signed [31:0] object_ident;
        logic signed [31:0] object_class;
        logic [63:0]        coord_first_bits;
        logic [63:0]        coord_second_bits;
        logic [63:0]        coord_third_bits;
        logic [2:0]         status;
        logic               last_of_run;
    } rec_word_t;

endpackage

/* rtl/core/ofbp_core.sv */
// Per-byte frame parsing state and record generation.
module ofbp_core #(
    parameter int unsigned COUNT_LIMIT_MAX = ofbp_pkg::COUNT_LIMIT_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [16:0]         max_objects,
    input  logic                take,
    input  ofbp_pkg::byte_word_t byte_word,
    output logic [1:0]          push_count,
    output ofbp_pkg::rec_word_t push_first,
    output ofbp_pkg::rec_word_t push_second
);
    import ofbp_pkg::*;

    phase_t      phase_reg, phase_next, phase_adv;
    logic [2:0]  idx_reg, idx_next, idx_adv;
    logic [63:0] shift_reg, shift_next, shift_adv;
    logic [31:0] held_fn_reg, held_fn_next;
    logic [63:0] held_ts_reg, held_ts_next;
    logic [16:0] remaining_reg, remaining_next, remaining_adv;
    logic [31:0] held_ident_reg, held_ident_next;
    logic [31:0] held_class_reg, held_class_next;
    logic [63:0] held_coord_a_reg, held_coord_a_next;
    logic [63:0] held_coord_b_reg, held_coord_b_next;
    logic [2:0]  err_reg, err_next, err_adv;
    logic [4:0]  seen_reg, seen_next, seen_adv;

    logic [63:0] assembled;
    logic        wide_field;
    logic        field_done;
    logic [31:0] count_val;
    logic        count_fits;
    logic [16:0] remaining_dec;
    logic        rec_valid;
    logic [2:0]  done_status;
    rec_word_t   rec;
    rec_word_t   done;

    // The byte lands in its little-endian slot of the field being assembled.
    assign assembled  = shift_reg | ({56'd0, byte_word.data_byte} << {idx_reg, 3'b000});
    assign wide_field = (phase_reg == PH_TIMESTAMP) || (phase_reg == PH_COORD_A) ||
                        (phase_reg == PH_COORD_B) || (phase_reg == PH_COORD_C);
    assign field_done = wide_field ? (idx_reg == 3'd7) : (idx_reg == 3'd3);
    assign count_val  = assembled[31:0];
    assign count_fits = (count_val <= {15'd0, max_objects}) &&
                        (count_val <= 32'(COUNT_LIMIT_MAX));
    assign remaining_dec = (remaining_reg != 17'd0) ? remaining_reg - 17'd1 : remaining_reg;

    // Next state while parsing, before the end of frame restart.
    always_comb
    begin
        phase_adv         = phase_reg;
        err_adv           = err_reg;
        idx_adv           = idx_reg;
        shift_adv         = shift_reg;
        remaining_adv     = remaining_reg;
        seen_adv          = seen_reg;
        held_fn_next      = held_fn_reg;
        held_ts_next      = held_ts_reg;
        held_ident_next   = held_ident_reg;
        held_class_next   = held_class_reg;
        held_coord_a_next = held_coord_a_reg;
        held_coord_b_next = held_coord_b_reg;
        if (take)
        begin
            if (seen_reg < 5'(HEADER_BYTES))
            begin
                seen_adv = seen_reg + 5'd1;
            end
            if (err_reg == ST_OK)
            begin
                unique case (phase_reg)
                    PH_MARKER:
                    begin
                        if (byte_word.data_byte == CH_MARKER) phase_adv = PH_COUNT;
                        else err_adv = ST_NO_MARKER;
                    end
                    PH_DELIM:
                    begin
                        if (byte_word.data_byte == CH_DELIM) phase_adv = PH_IDENT;
                        else err_adv = ST_NO_DELIM;
                    end
                    PH_TAIL:
                    begin
                        if (byte_word.data_byte == CH_MARKER) phase_adv = PH_END;
                        else err_adv = ST_TRAILING;
                    end
                    PH_END:
                    begin
                        err_adv = ST_TRAILING;
                    end
                    default:
                    begin
                        if (!field_done)
                        begin
                            shift_adv = assembled;
                            idx_adv   = idx_reg + 3'd1;
                        end
                        else
                        begin
                            shift_adv = '0;
                            idx_adv   = '0;
                            unique case (phase_reg)
                                PH_FRAME_NO:
                                begin
                                    held_fn_next = assembled[31:0];
                                    phase_adv    = PH_TIMESTAMP;
                                end
                                PH_TIMESTAMP:
                                begin
                                    held_ts_next = assembled;
                                    phase_adv    = PH_MARKER;
                                end
                                PH_COUNT:
                                begin
                                    if (count_val[31]) err_adv = ST_NEG_COUNT;
                                    else if (!count_fits) err_adv = ST_OVER_LIMIT;
                                    else
                                    begin
                                        remaining_adv = count_val[16:0];
                                        phase_adv = (count_val == 32'd0) ? PH_TAIL : PH_DELIM;
                                    end
                                end
                                PH_IDENT:
                                begin
                                    held_ident_next = assembled[31:0];
                                    phase_adv       = PH_CLASS;
                                end
                                PH_CLASS:
                                begin
                                    held_class_next = assembled[31:0];
                                    phase_adv       = PH_COORD_A;
                                end
                                PH_COORD_A:
                                begin
                                    held_coord_a_next = assembled;
                                    phase_adv         = PH_COORD_B;
                                end
                                PH_COORD_B:
                                begin
                                    held_coord_b_next = assembled;
                                    phase_adv         = PH_COORD_C;
                                end
                                default:
                                begin
                                    remaining_adv = remaining_dec;
                                    phase_adv = (remaining_dec != 17'd0) ? PH_DELIM : PH_TAIL;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    // The last byte of a frame puts the parser back at the frame number.
    always_comb
    begin
        if (take && byte_word.last_byte)
        begin
            phase_next     = PH_FRAME_NO;
            err_next       = ST_OK;
            idx_next       = '0;
            shift_next     = '0;
            remaining_next = '0;
            seen_next      = '0;
        end
        else
        begin
            phase_next     = phase_adv;
            err_next       = err_adv;
            idx_next       = idx_adv;
            shift_next     = shift_adv;
            remaining_next = remaining_adv;
            seen_next      = seen_adv;
        end
    end

    // Records caused by the current byte.
    always_comb
    begin
        rec_valid = take && (err_reg == ST_OK) && field_done &&
                    (((phase_reg == PH_COUNT) && !count_val[31] && count_fits) ||
                     (phase_reg == PH_COORD_C));

        if (seen_adv < 5'(HEADER_BYTES)) done_status = ST_SHORT;
        else if (err_adv != ST_OK) done_status = err_adv;
        else if (phase_adv == PH_DELIM) done_status = ST_NO_DELIM;
        else if ((phase_adv == PH_TAIL) || (phase_adv == PH_END)) done_status = ST_OK;
        else done_status = ST_TRUNCATED;

        rec = '0;
        if (phase_reg == PH_COUNT)
        begin
            rec.record_kind    = REC_HEADER;
            rec.frame_num      = held_fn_reg;
            rec.timestamp_bits = held_ts_reg;
            rec.object_count   = count_val[16:0];
        end
        else
        begin
            rec.record_kind       = REC_OBJECT;
            rec.object_ident      = held_ident_reg;
            rec.object_class      = held_class_reg;
            rec.coord_first_bits  = held_coord_a_reg;
            rec.coord_second_bits = held_coord_b_reg;
            rec.coord_third_bits  = assembled;
        end
        rec.last_of_run = !byte_word.last_byte;

        done             = '0;
        done.record_kind = REC_DONE;
        done.status      = done_status;
        done.last_of_run = 1'b1;

        push_first  = rec_valid ? rec : done;
        push_second = done;
        push_count  = {1'b0, rec_valid} + {1'b0, take && byte_word.last_byte};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FRAME_NO;
            err_reg          <= ST_OK;
            idx_reg          <= '0;
            shift_reg        <= '0;
            remaining_reg    <= '0;
            seen_reg         <= '0;
            held_fn_reg      <= '0;
            held_ts_reg      <= '0;
            held_ident_reg   <= '0;
            held_class_reg   <= '0;
            held_coord_a_reg <= '0;
            held_coord_b_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            err_reg          <= err_next;
            idx_reg          <= idx_next;
            shift_reg        <= shift_next;
            remaining_reg    <= remaining_next;
            seen_reg         <= seen_next;
            held_fn_reg      <= held_fn_next;
            held_ts_reg      <= held_ts_next;
            held_ident_reg   <= held_ident_next;
            held_class_reg   <= held_class_next;
            held_coord_a_reg <= held_coord_a_next;
            held_coord_b_reg <= held_coord_b_next;
        end
    end

endmodule

/* rtl/core/ofbp_out_queue.sv */
// Small record queue that takes up to two records a cycle and delivers one.
module ofbp_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_count,
    input  ofbp_pkg::rec_word_t push_first,
    input  ofbp_pkg::rec_word_t push_second,
    output logic                room_for_two,
    output logic                rec_valid,
    input  logic                rec_ready,
    output ofbp_pkg::rec_word_t rec_word
);
    import ofbp_pkg::*;

    localparam int unsigned LEVEL_W = $clog2(OUT_DEPTH + 1);

    rec_word_t          q_reg [OUT_DEPTH];
    rec_word_t          q_next [OUT_DEPTH];
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] level_after_pop;
    logic               pop;

    assign pop          = rec_valid && rec_ready;
    assign rec_valid    = (level_reg != '0);
    assign rec_word     = q_reg[0];
    assign room_for_two = (level_reg <= LEVEL_W'(OUT_DEPTH - 2));

    assign level_after_pop = level_reg - {{(LEVEL_W-1){1'b0}}, pop};
    assign level_next      = level_after_pop + {{(LEVEL_W-2){1'b0}}, push_count};

    // The head always sits in entry zero; a pop moves every entry down one.
    always_comb
    begin
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            if (pop && (i < OUT_DEPTH - 1)) q_next[i] = q_reg[(i + 1) % OUT_DEPTH];
            else q_next[i] = q_reg[i];
            if ((push_count != 2'd0) && (level_after_pop == LEVEL_W'(i)))
            begin
                q_next[i] = push_first;
            end
            if ((push_count == 2'd2) && (level_after_pop + LEVEL_W'(1) == LEVEL_W'(i)))
            begin
                q_next[i] = push_second;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

endmodule

/* rtl/core/object_frame_byte_parser_top.sv */
// Top level of the object frame byte parser: byte channel in, record channel out.
// Throughput: one frame byte per cycle while the output queue has room for two records.
// The parser updates its state and queues the records of a byte in the cycle it takes that byte.
// A closing byte that also completes a header or object record causes two records; they leave in turn.
// The four-record output queue sets how long the input keeps flowing while the output stalls.
// Reset (rst_n, asynchronous, active low) starts a new frame, empties the queue, sets the limit to 10000.
module object_frame_byte_parser_top #(
    parameter int unsigned COUNT_LIMIT_MAX = ofbp_pkg::COUNT_LIMIT_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [16:0]          cfg_wr_data,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  ofbp_pkg::byte_word_t byte_word,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output ofbp_pkg::rec_word_t  rec_word
);
    import ofbp_pkg::*;

    logic [16:0] max_objects_reg;
    logic        take;
    logic        room_for_two;
    logic [1:0]  push_count;
    rec_word_t   push_first;
    rec_word_t   push_second;

    // The limit register; users must write it only while no frame is in flight, unchecked by the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_objects_reg <= MAX_OBJECTS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_objects_reg <= cfg_wr_data;
        end
    end

    // A word is taken only when the queue can hold both records it might cause,
    // so the parser never has to hold a byte back.
    assign byte_ready = room_for_two;
    assign take       = byte_valid && byte_ready;

    ofbp_core #(
        .COUNT_LIMIT_MAX(COUNT_LIMIT_MAX)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_objects(max_objects_reg),
        .take       (take),
        .byte_word  (byte_word),
        .push_count (push_count),
        .push_first (push_first),
        .push_second(push_second)
    );

    ofbp_out_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (push_first),
        .push_second (push_second),
        .room_for_two(room_for_two),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec_word    (rec_word)
    );

    // A frame done record always closes the run of records of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && (rec_word.record_kind == REC_DONE)) |-> rec_word.last_of_run)
        else $error("done record without last_of_run");

    // Header and object records carry no status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && (rec_word.record_kind != REC_DONE)) |-> (rec_word.status == ST_OK))
        else $error("status set on a non-done record");

    // The closing byte of a frame always leaves a record waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_ready && byte_word.last_byte) |=> rec_valid)
        else $error("no record after the last byte of a frame");

endmodule

/* verif/frame_record_checker.sv */
// Record checker for the object frame byte parser: predicts records from taken bytes and compares.
module frame_record_checker
    import ofbp_pkg::*;
#(
    parameter int unsigned COUNT_LIMIT_MAX = COUNT_LIMIT_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  byte_word_t  byte_word,
    input  logic        rec_valid,
    input  logic        rec_ready,
    input  rec_word_t   rec_word,
    output int          mismatch_count,
    output int          pending
);

    logic [16:0] limit_reg;
    phase_t      phase;
    logic [2:0]  field_idx;
    logic [63:0] field_acc;
    logic [31:0] frame_no_hold;
    logic [63:0] stamp_hold;
    logic [16:0] objects_left;
    logic [31:0] ident_hold;
    logic [31:0] class_hold;
    logic [63:0] coord_a_hold;
    logic [63:0] coord_b_hold;
    logic [2:0]  frame_error;
    logic [4:0]  header_bytes_seen;

    rec_word_t   expected_records[$];
    rec_word_t   byte_records[$];
    int          mismatches = 0;
    int          waiting = 0;

    assign mismatch_count = mismatches;
    assign pending        = waiting;

    task automatic start_new_frame();
        phase             = PH_FRAME_NO;
        field_idx         = '0;
        field_acc         = '0;
        objects_left      = '0;
        frame_error       = ST_OK;
        header_bytes_seen = '0;
    endtask

    // A complete little-endian field moves the frame on, unless it is a rejected count.
    task automatic close_field(input logic [63:0] value);
        rec_word_t   rec;
        logic [31:0] count;
        logic [31:0] cap;
        count = value[31:0];
        cap   = (limit_reg > COUNT_LIMIT_MAX) ? 32'(COUNT_LIMIT_MAX) : 32'(limit_reg);
        rec   = '0;
        case (phase)
            PH_FRAME_NO:
            begin
                frame_no_hold = value[31:0];
                phase         = PH_TIMESTAMP;
            end
            PH_TIMESTAMP:
            begin
                stamp_hold = value;
                phase      = PH_MARKER;
            end
            PH_COUNT:
            begin
                if (count[31])
                    frame_error = ST_NEG_COUNT;
                else if (count > cap)
                    frame_error = ST_OVER_LIMIT;
                else
                begin
                    rec.record_kind    = REC_HEADER;
                    rec.frame_num      = frame_no_hold;
                    rec.timestamp_bits = stamp_hold;
                    rec.object_count   = count[16:0];
                    byte_records = {byte_records, rec};
                    objects_left = count[16:0];
                    phase        = (count == 0) ? PH_TAIL : PH_DELIM;
                end
            end
            PH_IDENT:
            begin
                ident_hold = value[31:0];
                phase      = PH_CLASS;
            end
            PH_CLASS:
            begin
                class_hold = value[31:0];
                phase      = PH_COORD_A;
            end
            PH_COORD_A:
            begin
                coord_a_hold = value;
                phase        = PH_COORD_B;
            end
            PH_COORD_B:
            begin
                coord_b_hold = value;
                phase        = PH_COORD_C;
            end
            default:
            begin
                rec.record_kind       = REC_OBJECT;
                rec.object_ident      = ident_hold;
                rec.object_class      = class_hold;
                rec.coord_first_bits  = coord_a_hold;
                rec.coord_second_bits = coord_b_hold;
                rec.coord_third_bits  = value;
                byte_records = {byte_records, rec};
                if (objects_left != 0)
                    objects_left = objects_left - 1'b1;
                phase = (objects_left != 0) ? PH_DELIM : PH_TAIL;
            end
        endcase
    endtask

    task automatic parse_frame_byte(input logic [7:0] data, input logic closing);
        logic [63:0] merged;
        int          width;
        rec_word_t   done_rec;
        logic [2:0]  frame_status;
        byte_records.delete();
        if (header_bytes_seen < HEADER_BYTES)
            header_bytes_seen = header_bytes_seen + 1'b1;
        if (frame_error == ST_OK)
        begin
            case (phase)
                PH_MARKER:
                    if (data == CH_MARKER) phase = PH_COUNT;
                    else frame_error = ST_NO_MARKER;
                PH_DELIM:
                    if (data == CH_DELIM) phase = PH_IDENT;
                    else frame_error = ST_NO_DELIM;
                PH_TAIL:
                    if (data == CH_MARKER) phase = PH_END;
                    else frame_error = ST_TRAILING;
                PH_END:
                    frame_error = ST_TRAILING;
                default:
                begin
                    width  = (phase == PH_TIMESTAMP || phase == PH_COORD_A ||
                              phase == PH_COORD_B || phase == PH_COORD_C) ? 8 : 4;
                    merged = field_acc | (64'(data) << (8 * field_idx));
                    if (int'(field_idx) + 1 < width)
                    begin
                        field_acc = merged;
                        field_idx = field_idx + 1'b1;
                    end
                    else
                    begin
                        field_acc = '0;
                        field_idx = '0;
                        close_field(merged);
                    end
                end
            endcase
        end
        if (closing)
        begin
            if (header_bytes_seen < HEADER_BYTES)
                frame_status = ST_SHORT;
            else if (frame_error != ST_OK)
                frame_status = frame_error;
            else if (phase == PH_DELIM)
                frame_status = ST_NO_DELIM;
            else if (phase == PH_TAIL || phase == PH_END)
                frame_status = ST_OK;
            else
                frame_status = ST_TRUNCATED;
            done_rec             = '0;
            done_rec.record_kind = REC_DONE;
            done_rec.status      = frame_status;
            byte_records = {byte_records, done_rec};
            start_new_frame();
        end
        if (byte_records.size() > 0)
            byte_records[byte_records.size() - 1].last_of_run = 1'b1;
        expected_records = {expected_records, byte_records};
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic compare_record(input rec_word_t got);
        rec_word_t want;
        if (expected_records.size() == 0)
        begin
            $display("%0t: record_kind mismatch, expected none, actual %h", $time,
                     got.record_kind);
            mismatches++;
        end
        else
        begin
            want = expected_records.pop_front();
            check_field("record_kind", 64'(want.record_kind), 64'(got.record_kind));
            check_field("frame_num", 64'(want.frame_num), 64'(got.frame_num));
            check_field("timestamp_bits", want.timestamp_bits, got.timestamp_bits);
            check_field("object_count", 64'(want.object_count), 64'(got.object_count));
            check_field("object_ident", 64'(want.object_ident), 64'(got.object_ident));
            check_field("object_class", 64'(want.object_class), 64'(got.object_class));
            check_field("coord_first_bits", want.coord_first_bits, got.coord_first_bits);
            check_field("coord_second_bits", want.coord_second_bits, got.coord_second_bits);
            check_field("coord_third_bits", want.coord_third_bits, got.coord_third_bits);
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     = MAX_OBJECTS_RESET;
            frame_no_hold = '0;
            stamp_hold    = '0;
            ident_hold    = '0;
            class_hold    = '0;
            coord_a_hold  = '0;
            coord_b_hold  = '0;
            start_new_frame();
            expected_records.delete();
            waiting = 0;
        end
        else
        begin
            if (rec_valid && rec_ready)
                compare_record(rec_word);
            if (cfg_wr_en)
                limit_reg = cfg_wr_data;
            if (byte_valid && byte_ready)
                parse_frame_byte(byte_word.data_byte, byte_word.last_byte);
            waiting = expected_records.size();
        end
    end

endmodule

/* verif/object_frame_byte_parser_top_test.sv */
// Testbench top for the object frame byte parser: frame stimulus, output stalls and verdict.
module object_frame_byte_parser_top_test;
    import ofbp_pkg::*;

    // Sender and receiver behavior codes.
    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } rx_mode_t;

    typedef enum int {
        FR_CLEAN,
        FR_NOISE,
        FR_BAD_MARKER,
        FR_CUT,
        FR_CORRUPT
    } frame_style_t;

    typedef enum int {
        TAIL_NONE,
        TAIL_MARK,
        TAIL_MARK_EXTRA,
        TAIL_JUNK
    } tail_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;
    logic        byte_valid;
    logic        byte_ready;
    byte_word_t  byte_word;
    logic        rec_valid;
    logic        rec_ready;
    rec_word_t   rec_word;
    int          mismatch_count;
    int          pending;

    // Bytes of the frame being built, sent front to back.
    logic [7:0]  frame_buf[$];
    int          bytes_sent = 0;
    int          burst_left = 0;
    bit          steady_sender = 1'b0;
    // Effective object limit, used only to aim counts at the boundary.
    int unsigned limit_now = 32'(MAX_OBJECTS_RESET);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    object_frame_byte_parser_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_word   (byte_word),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec_word    (rec_word)
    );

    frame_record_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .byte_word      (byte_word),
        .rec_valid      (rec_valid),
        .rec_ready      (rec_ready),
        .rec_word       (rec_word),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // Append a value to the frame, least significant byte first.
    function automatic void add_le(input logic [63:0] value, input int count);
        for (int i = 0; i < count; i++)
            frame_buf = {frame_buf, value[8 * i +: 8]};
    endfunction

    // Frame number, timestamp, marker and count: the 17 header bytes.
    function automatic void add_header(input logic [31:0] number, input logic [63:0] stamp,
                                       input logic [7:0] mark, input logic [31:0] count);
        add_le(64'(number), 4);
        add_le(stamp, 8);
        frame_buf = {frame_buf, mark};
        add_le(64'(count), 4);
    endfunction

    function automatic void add_object(input logic [7:0] delim, input logic [31:0] ident,
                                       input logic [31:0] label, input logic [63:0] first,
                                       input logic [63:0] second, input logic [63:0] third);
        frame_buf = {frame_buf, delim};
        add_le(64'(ident), 4);
        add_le(64'(label), 4);
        add_le(first, 8);
        add_le(second, 8);
        add_le(third, 8);
    endfunction

    // Random 64-bit field with the all-zero and all-one patterns mixed in.
    function automatic logic [63:0] pick_word64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Hold the sender idle for a number of cycles. Every path that lets time pass
    // after an accepted word starts here, so a word is never presented twice.
    task automatic sender_pause(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
    endtask

    // Present one byte and wait for the handshake. Bursts of random length are
    // separated by random gaps unless the sender is in a steady phase.
    task automatic send_byte(input logic [7:0] value, input logic closing);
        if (!steady_sender && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            sender_pause($urandom_range(0, 4));
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_word  <= {value, closing};
        do @(posedge clk); while (!byte_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frame_buf.delete();
    endtask

    // Let every predicted record come out, then let the parser settle, since a byte
    // in mid-field leaves nothing to wait for.
    task automatic wait_for_drain();
        sender_pause(1);
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_limit(input logic [16:0] value);
        wait_for_drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        limit_now = (value > COUNT_LIMIT_MAX_DEF) ? COUNT_LIMIT_MAX_DEF : 32'(value);
    endtask

    // Hand-built frames: each error status, the short-frame override, and the
    // closing bytes that also finish a field and so make two records.
    task automatic send_directed_frames();
        // A single byte is a short frame.
        frame_buf = {frame_buf, 8'hFF};
        send_frame();
        // A bad marker seen before a short end still reports short.
        add_header(32'h1, 64'h2, 8'h00, 32'h0);
        frame_buf = frame_buf[0:15];
        send_frame();
        // Empty frame ending on the last count byte: header and done together.
        add_header(32'h0, 64'h0, CH_MARKER, 32'h0);
        send_frame();
        // Empty frame with the optional closing marker.
        add_header(32'h7FFF_FFFF, '1, CH_MARKER, 32'h0);
        frame_buf = {frame_buf, CH_MARKER};
        send_frame();
        // One object with extreme fields, ending on its last coordinate byte.
        add_header(32'h8000_0000, '1, CH_MARKER, 32'h1);
        add_object(CH_DELIM, 32'h7FFF_FFFF, 32'h8000_0000, '0, '1, 64'h8000_0000_0000_0001);
        send_frame();
        // Two objects, closing marker, then one byte too many.
        add_header(32'h5, pick_word64(), CH_MARKER, 32'h2);
        add_object(CH_DELIM, $urandom(), $urandom(), pick_word64(), pick_word64(),
                   pick_word64());
        add_object(CH_DELIM, $urandom(), $urandom(), pick_word64(), pick_word64(),
                   pick_word64());
        frame_buf = {frame_buf, CH_MARKER};
        frame_buf = {frame_buf, CH_MARKER};
        send_frame();
        // Something other than the closing marker after the objects.
        add_header(32'h6, 64'h0, CH_MARKER, 32'h0);
        frame_buf = {frame_buf, 8'h00};
        send_frame();
        // Negative count; the object that follows is ignored.
        add_header(32'h7, 64'h0, CH_MARKER, 32'hFFFF_FFFF);
        add_object(CH_DELIM, 32'h1, 32'h2, '0, '0, '0);
        send_frame();
        // One above the limit, then exactly the limit with the frame ending
        // where the first delimiter is due.
        add_header(32'h8, 64'h0, CH_MARKER, limit_now + 1);
        send_frame();
        add_header(32'h9, 64'h0, CH_MARKER, limit_now);
        send_frame();
        // Wrong byte where the delimiter belongs.
        add_header(32'hA, 64'h0, CH_MARKER, 32'h1);
        add_object(CH_MARKER, 32'h1, 32'h2, '0, '0, '0);
        send_frame();
        // Full-length header with a bad marker.
        add_header(32'hB, 64'h0, 8'h41, 32'h0);
        send_frame();
        // Frame cut inside an object identifier.
        add_header(32'hC, 64'h0, CH_MARKER, 32'h1);
        add_object(CH_DELIM, 32'h1234_5678, 32'h0, '0, '0, '0);
        frame_buf = frame_buf[0:19];
        send_frame();
    endtask

    // Mostly well-formed frames with random content; the rest are noise,
    // damaged or cut frames. Counts are aimed at the limit now and then.
    task automatic send_random_frame();
        frame_style_t style;
        tail_kind_t   tail;
        logic [31:0]  count;
        int           objects;
        int           pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)       style = FR_NOISE;
        else if (pick == 2) style = FR_BAD_MARKER;
        else if (pick < 5)  style = FR_CUT;
        else if (pick < 7)  style = FR_CORRUPT;
        else                style = FR_CLEAN;

        if (style == FR_NOISE)
        begin
            repeat ($urandom_range(1, 40))
                frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: count = limit_now;
                1: count = limit_now + 1;
                2: count = $urandom();
                3: count = 32'h8000_0000 | $urandom();
                default: count = $urandom_range(0, 3);
            endcase
            objects = (count <= 3) ? int'(count) : $urandom_range(0, 2);
            add_header($urandom(), pick_word64(),
                       (style == FR_BAD_MARKER) ? 8'($urandom_range(0, 255)) : CH_MARKER,
                       count);
            repeat (objects)
                add_object(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : CH_DELIM,
                           $urandom(), $urandom(), pick_word64(), pick_word64(),
                           pick_word64());
            tail = tail_kind_t'($urandom_range(0, 3));
            case (tail)
                TAIL_MARK:
                    frame_buf = {frame_buf, CH_MARKER};
                TAIL_MARK_EXTRA:
                begin
                    frame_buf = {frame_buf, CH_MARKER};
                    repeat ($urandom_range(1, 3))
                        frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
                end
                TAIL_JUNK:
                    frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
                default: ;
            endcase
            if (style == FR_CUT)
                frame_buf = frame_buf[0:$urandom_range(0, frame_buf.size() - 1)];
            else if (style == FR_CORRUPT)
                frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        send_frame();
    endtask

    // Receiver: switches at random between stall patterns, from always ready to
    // long blocked stretches.
    initial
    begin
        rx_mode_t stall_mode;
        int       mode_left;
        int       tick;
        rec_ready  = 1'b0;
        stall_mode = RX_OPEN;
        mode_left  = 0;
        tick       = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(50, 400);
            end
            mode_left--;
            tick++;
            case (stall_mode)
                RX_OPEN:     rec_ready <= 1'b1;
                RX_RANDOM:   rec_ready <= ($urandom_range(0, 1) == 1);
                RX_PERIODIC: rec_ready <= ((tick % 7) < 3);
                default:     rec_ready <= ((tick % 32) >= 24);
            endcase
        end
    end

    // Main sequence: reset, directed frames at the reset limit, then random
    // phases that each start with a new limit written while the block is idle.
    initial
    begin
        logic [16:0] limit_plan[7];
        int          target;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        byte_valid  = 1'b0;
        byte_word   = '0;
        limit_plan  = '{MAX_OBJECTS_3D, 17'd0, 17'h1FFFF, 17'd1, 17'd0, 17'd3,
                        MAX_OBJECTS_RESET};
        limit_plan[4] = 17'($urandom_range(2, 99999));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_directed_frames();

        foreach (limit_plan[p])
        begin
            write_limit(limit_plan[p]);
            steady_sender = ($urandom_range(0, 2) == 0);
            burst_left    = 0;
            target        = bytes_sent + 30;
            while (bytes_sent < target)
            begin
                // Now and then hold the sender until every record is out.
                if ($urandom_range(0, 9) == 0)
                    wait_for_drain();
                send_random_frame();
            end
        end

        sender_pause(1);
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
